@@ rtl/core/qs_pkg.sv @@
// ----------------------------------------------------------------------------
// qs_pkg
// Shared types and constants for the quicksort engine.
// ----------------------------------------------------------------------------
package qs_pkg;

   localparam int DATA_W    = 32;
   localparam int DEPTH_DEF = 64;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   typedef enum logic {
      OP_STORE,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                last;
      logic [DATA_W-1:0]   value;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_POP,
      ST_RANGE,
      ST_PIV,
      ST_CMP,
      ST_SWPA,
      ST_SWPB,
      ST_FIN,
      ST_FINA,
      ST_FINB,
      ST_PUSH2,
      ST_EMRD,
      ST_EMWR
   } state_type;

endpackage

@@ rtl/core/qs_if.sv @@
// ----------------------------------------------------------------------------
// qs_if
// Valid/ready channels of the quicksort engine.
// ----------------------------------------------------------------------------
interface qs_req_if;
   logic                        valid;
   logic                        ready;
   logic [qs_pkg::DATA_W-1:0]   value;
   logic                        last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface qs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [qs_pkg::DATA_W-1:0]   sorted_value;
   logic                        end_of_set;
   logic                        overflow;

   modport source (output valid, output sorted_value, output end_of_set,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input end_of_set,
                   input overflow, output ready);
endinterface

@@ rtl/core/quicksort_engine.sv @@
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects a set of signed values and returns it in ascending order.
//
//   channel   dir   beat contents
//   req_bus   in    value, last
//   rsp_bus   out   sorted_value, end_of_set, overflow
//
// Loading: one beat per cycle into a 4-deep queue; the back end drains one per
// cycle, so ready stays high while a set streams in.
// Sorting: a partition pops a range, reads the pivot, compares each element;
// a swap is two writes to the element store (one read and one write port).
// Emit: each result is a store read, then the output register is loaded.
// req_bus.ready drops only when the queue fills during sort or emit.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module quicksort_engine #(
   parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   qs_req_if.sink     req_bus,
   qs_rsp_if.source   rsp_bus
);
   import qs_pkg::*;

   logic     push_valid;
   cmd_type  push_cmd;
   logic     queue_full;
   logic     pop_valid;
   cmd_type  pop_cmd;
   logic     pop_ready;

   qs_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   qs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   qs_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

@@ rtl/core/qs_front.sv @@
// ----------------------------------------------------------------------------
// qs_front
// Accepts input beats and tags each one as store or drop by set position.
// ----------------------------------------------------------------------------
module qs_front #(
   parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   qs_req_if.sink            req,
   output logic              push_valid,
   output qs_pkg::cmd_type   push_cmd,
   input  logic              queue_full
);
   import qs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          room;
   logic          accept;

   assign room       = (count_ff < CW'(DEPTH));
   assign req.ready  = !queue_full;
   assign accept     = req.valid && !queue_full;
   assign push_valid = accept;

   always_comb begin
      push_cmd.op    = room ? OP_STORE : OP_DROP;
      push_cmd.last  = req.last;
      push_cmd.value = req.value;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req.last) begin
            count_in = '0;
         end else if (room) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/qs_queue.sv @@
// ----------------------------------------------------------------------------
// qs_queue
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module qs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  qs_pkg::cmd_type   push_cmd,
   output logic              full,
   output logic              pop_valid,
   output qs_pkg::cmd_type   pop_cmd,
   input  logic              pop_ready
);
   import qs_pkg::*;

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff;
   logic [QPTR_W-1:0]   wptr_in;
   logic [QPTR_W-1:0]   rptr_ff;
   logic [QPTR_W-1:0]   rptr_in;
   logic [QCNT_W-1:0]   fill_ff;
   logic [QCNT_W-1:0]   fill_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (fill_ff == QCNT_W'(QDEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_cmd   = slot_ff[rptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wptr_in = do_push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + QPTR_W'(1) : rptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/qs_back.sv @@
// ----------------------------------------------------------------------------
// qs_back
// Element store, range-stack quicksort sequencer and result register.
// ----------------------------------------------------------------------------
module qs_back #(
   parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  qs_pkg::cmd_type   pop_cmd,
   output logic              pop_ready,
   qs_rsp_if.source          rsp
);
   import qs_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = 2 * IW;

   // element store and range stack
   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [SW-1:0]     stack_mem [DEPTH];

   logic              st_we;
   logic [IW-1:0]     st_waddr;
   logic [DATA_W-1:0] st_wdata;
   logic              st_re;
   logic [IW-1:0]     st_raddr;
   logic [DATA_W-1:0] st_rd_ff;

   logic              sk_we;
   logic [IW-1:0]     sk_waddr;
   logic [SW-1:0]     sk_wdata;
   logic              sk_re;
   logic [IW-1:0]     sk_raddr;
   logic [SW-1:0]     sk_rd_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     sp_ff, sp_in;
   logic              dropped_ff, dropped_in;
   logic [IW-1:0]     lo_ff, lo_in;
   logic [IW-1:0]     hi_ff, hi_in;
   logic [IW-1:0]     mark_ff, mark_in;
   logic [IW-1:0]     k_ff, k_in;
   logic [DATA_W-1:0] pivot_ff, pivot_in;
   logic [DATA_W-1:0] kval_ff, kval_in;

   logic              ov_ff, ov_in;
   logic [DATA_W-1:0] ov_value_ff, ov_value_in;
   logic              ov_end_ff, ov_end_in;
   logic              ov_ovf_ff, ov_ovf_in;

   logic [IW-1:0]     last_idx;
   logic [IW-1:0]     stk_lo;
   logic [IW-1:0]     stk_hi;
   logic              out_free;

   assign last_idx = IW'(count_ff - CW'(1));
   assign stk_lo   = sk_rd_ff[SW-1:IW];
   assign stk_hi   = sk_rd_ff[IW-1:0];
   assign out_free = !ov_ff || rsp.ready;

   assign pop_ready        = (state_ff == ST_LOAD);
   assign rsp.valid        = ov_ff;
   assign rsp.sorted_value = ov_value_ff;
   assign rsp.end_of_set   = ov_end_ff;
   assign rsp.overflow     = ov_ovf_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      sp_in       = sp_ff;
      dropped_in  = dropped_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mark_in     = mark_ff;
      k_in        = k_ff;
      pivot_in    = pivot_ff;
      kval_in     = kval_ff;
      ov_in       = ov_ff && !rsp.ready;
      ov_value_in = ov_value_ff;
      ov_end_in   = ov_end_ff;
      ov_ovf_in   = ov_ovf_ff;
      st_we       = 1'b0;
      st_waddr    = '0;
      st_wdata    = '0;
      st_re       = 1'b0;
      st_raddr    = '0;
      sk_we       = 1'b0;
      sk_waddr    = '0;
      sk_wdata    = '0;
      sk_re       = 1'b0;
      sk_raddr    = '0;

      case (state_ff)
         ST_LOAD: begin
            if (pop_valid) begin
               if (pop_cmd.op == OP_STORE) begin
                  st_we    = 1'b1;
                  st_waddr = IW'(count_ff);
                  st_wdata = pop_cmd.value;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (pop_cmd.last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            if (count_ff >= CW'(2)) begin
               sk_we    = 1'b1;
               sk_waddr = '0;
               sk_wdata = {IW'(0), last_idx};
               sp_in    = CW'(1);
               state_in = ST_POP;
            end else begin
               k_in     = '0;
               state_in = ST_EMRD;
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = ST_EMRD;
            end else begin
               sk_re    = 1'b1;
               sk_raddr = IW'(sp_ff - CW'(1));
               sp_in    = sp_ff - CW'(1);
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            lo_in = stk_lo;
            hi_in = stk_hi;
            if (stk_lo >= stk_hi) begin
               state_in = ST_POP;
            end else begin
               st_re    = 1'b1;
               st_raddr = stk_lo;
               state_in = ST_PIV;
            end
         end
         ST_PIV: begin
            pivot_in = st_rd_ff;
            mark_in  = lo_ff;
            k_in     = lo_ff + IW'(1);
            st_re    = 1'b1;
            st_raddr = lo_ff + IW'(1);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ($signed(st_rd_ff) < $signed(pivot_ff)) begin
               kval_in  = st_rd_ff;
               st_re    = 1'b1;
               st_raddr = mark_ff + IW'(1);
               state_in = ST_SWPA;
            end else if (k_ff == hi_ff) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff + IW'(1);
               st_re    = 1'b1;
               st_raddr = k_ff + IW'(1);
            end
         end
         ST_SWPA: begin
            st_we    = 1'b1;
            st_waddr = k_ff;
            st_wdata = st_rd_ff;
            mark_in  = mark_ff + IW'(1);
            state_in = ST_SWPB;
         end
         ST_SWPB: begin
            st_we    = 1'b1;
            st_waddr = mark_ff;
            st_wdata = kval_ff;
            if (k_ff == hi_ff) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff + IW'(1);
               st_re    = 1'b1;
               st_raddr = k_ff + IW'(1);
               state_in = ST_CMP;
            end
         end
         ST_FIN: begin
            st_re    = 1'b1;
            st_raddr = mark_ff;
            state_in = ST_FINA;
         end
         ST_FINA: begin
            st_we    = 1'b1;
            st_waddr = lo_ff;
            st_wdata = st_rd_ff;
            state_in = ST_FINB;
         end
         ST_FINB: begin
            st_we    = 1'b1;
            st_waddr = mark_ff;
            st_wdata = pivot_ff;
            if ({1'b0, mark_ff} > ({1'b0, lo_ff} + (IW + 1)'(1))) begin
               sk_we    = 1'b1;
               sk_waddr = IW'(sp_ff);
               sk_wdata = {lo_ff, mark_ff - IW'(1)};
               sp_in    = sp_ff + CW'(1);
            end
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            if ({1'b0, hi_ff} > ({1'b0, mark_ff} + (IW + 1)'(1))) begin
               sk_we    = 1'b1;
               sk_waddr = IW'(sp_ff);
               sk_wdata = {mark_ff + IW'(1), hi_ff};
               sp_in    = sp_ff + CW'(1);
            end
            state_in = ST_POP;
         end
         ST_EMRD: begin
            st_re    = 1'b1;
            st_raddr = k_ff;
            state_in = ST_EMWR;
         end
         ST_EMWR: begin
            if (out_free) begin
               ov_in       = 1'b1;
               ov_value_in = st_rd_ff;
               ov_end_in   = (k_ff == last_idx);
               ov_ovf_in   = dropped_ff;
               if (k_ff == last_idx) begin
                  count_in   = '0;
                  sp_in      = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in     = k_ff + IW'(1);
                  state_in = ST_EMRD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         sp_ff      <= '0;
         dropped_ff <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         sp_ff      <= sp_in;
         dropped_ff <= dropped_in;
         ov_ff      <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mark_ff     <= mark_in;
      k_ff        <= k_in;
      pivot_ff    <= pivot_in;
      kval_ff     <= kval_in;
      ov_value_ff <= ov_value_in;
      ov_end_ff   <= ov_end_in;
      ov_ovf_ff   <= ov_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         st_rd_ff <= store_mem[st_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (sk_we) begin
         stack_mem[sk_waddr] <= sk_wdata;
      end
      if (sk_re) begin
         sk_rd_ff <= stack_mem[sk_raddr];
      end
   end

endmodule

@@ rtl/core/qs_checker.sv @@
// ----------------------------------------------------------------------------
// qs_checker
// Port-level checks on the result stream of the quicksort engine.
// ----------------------------------------------------------------------------
module qs_checker #(
   parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [qs_pkg::DATA_W-1:0]   rsp_sorted_value,
   input  logic                        rsp_end_of_set,
   input  logic                        rsp_overflow
);
   import qs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic              rsp_acc;
   logic              in_set_ff;
   logic [DATA_W-1:0] prev_ff;
   logic              ovf_ff;
   logic [CW-1:0]     beats_ff;

   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_set_ff <= 1'b0;
         beats_ff  <= '0;
      end else if (rsp_acc) begin
         in_set_ff <= !rsp_end_of_set;
         beats_ff  <= rsp_end_of_set ? '0 : beats_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         prev_ff <= rsp_sorted_value;
         ovf_ff  <= rsp_overflow;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
         && $stable(rsp_end_of_set) && $stable(rsp_overflow))
      else $error("result beat changed while stalled");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && in_set_ff |-> $signed(rsp_sorted_value) >= $signed(prev_ff))
      else $error("results not ascending within set");

   a_ovf_const: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && in_set_ff |-> rsp_overflow == ovf_ff)
      else $error("overflow flag changed within set");

   a_set_size: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> beats_ff < CW'(DEPTH))
      else $error("set longer than store depth");

endmodule

bind quicksort_engine qs_checker #(.DEPTH(DEPTH)) u_qs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_sorted_value (rsp_bus.sorted_value),
   .rsp_end_of_set   (rsp_bus.end_of_set),
   .rsp_overflow     (rsp_bus.overflow)
);
